// ===== rtl/core/pwl_gamma_pkg.sv =====
// ============================================================================
// pwl_gamma_pkg
// Shared constants and register codes for the piecewise linear gamma block.
// ============================================================================
package pwl_gamma_pkg;

    // Knot table size and effective pixel width
    localparam int TABLE_DEPTH = 64;
    localparam int PIXEL_BITS  = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int LAST_IDX    = TABLE_DEPTH - 1;

    // Fixed field widths
    localparam int PIX_W      = 16;
    localparam int ADDR_W     = 7;
    localparam int VAL_W      = 16;
    localparam int SHIFT_W    = 4;
    localparam int BASE_W     = 6;
    localparam int FRAC_W     = 15;
    localparam int NUM_BND    = 5;
    localparam int NUM_SEG    = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 36;

    // Bypass shift and opcode values
    localparam int   BYPASS_SHIFT = 4;
    localparam logic OP_PIXEL     = 1'b0;
    localparam logic OP_WRITE     = 1'b1;

    localparam logic [PIX_W-1:0] PIX_MASK = PIX_W'((1 << PIXEL_BITS) - 1);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE     = 3'd0,
        REG_BOUNDARY_0 = 3'd1,
        REG_BOUNDARY_1 = 3'd2,
        REG_BOUNDARY_2 = 3'd3,
        REG_BOUNDARY_3 = 3'd4,
        REG_BOUNDARY_4 = 3'd5,
        REG_STEPS      = 3'd6,
        REG_BASES      = 3'd7
    } cfg_reg_t;

endpackage

// ===== rtl/core/pwl_gamma_if.sv =====
// ============================================================================
// pwl_gamma_if
// Valid/ready channels for input items and result items.
// ============================================================================
interface pwl_gamma_req_if;
    logic                                valid;
    logic                                ready;
    logic                                opcode;
    logic [pwl_gamma_pkg::PIX_W-1:0]     pixel_in;
    logic [pwl_gamma_pkg::ADDR_W-1:0]    table_address;
    logic [pwl_gamma_pkg::VAL_W-1:0]     table_value;

    modport source (output valid, opcode, pixel_in, table_address, table_value,
                    input ready);
    modport sink   (input valid, opcode, pixel_in, table_address, table_value,
                    output ready);
endinterface

interface pwl_gamma_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [pwl_gamma_pkg::PIX_W-1:0]     pixel_out;

    modport source (output valid, pixel_out, input ready);
    modport sink   (input valid, pixel_out, output ready);
endinterface

// ===== rtl/core/piecewise_linear_gamma_lut.sv =====
// ============================================================================
// piecewise_linear_gamma_lut
// Six-segment gamma curve with linear interpolation over a knot table.
// ============================================================================
// The block takes one item per clock as long as the result side keeps up;
// each stage has its own valid bit, so bubbles are squeezed out and the
// input accepts while a result waits, until every stage is full. Table
// write items travel down the same pipeline and update the 64x16 knot
// memory at the memory read stage, so each pixel sees exactly the writes
// accepted before it. The knot memory has one write port and two
// registered read ports (current and next knot); the extra final knot is
// a register. Stages: input register, segment select and offset, index
// and memory read, knot difference times fraction, round and add.
// Configuration is written through cfg_we/cfg_index/cfg_data while the
// pipeline is empty; the user must keep to this, the block does not check.
// ============================================================================
module piecewise_linear_gamma_lut (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_we,
    input  logic [pwl_gamma_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pwl_gamma_pkg::CFG_DATA_W-1:0]      cfg_data,
    pwl_gamma_req_if.sink                             req,
    pwl_gamma_rsp_if.source                           rsp
);

    localparam int PIX_W   = pwl_gamma_pkg::PIX_W;
    localparam int IDX_W   = pwl_gamma_pkg::IDX_W;
    localparam int SHIFT_W = pwl_gamma_pkg::SHIFT_W;
    localparam int BASE_W  = pwl_gamma_pkg::BASE_W;
    localparam int FRAC_W  = pwl_gamma_pkg::FRAC_W;
    localparam int VAL_W   = pwl_gamma_pkg::VAL_W;
    localparam int ADDR_W  = pwl_gamma_pkg::ADDR_W;

    // Stage payloads
    typedef struct packed {
        logic                 wr;
        logic [PIX_W-1:0]     pix;
        logic [ADDR_W-1:0]    addr;
        logic [VAL_W-1:0]     val;
    } s0_t;

    typedef struct packed {
        logic                 wr;
        logic                 byp;
        logic [PIX_W-1:0]     byp_val;
        logic [PIX_W-1:0]     off;
        logic [SHIFT_W-1:0]   shift;
        logic [BASE_W-1:0]    base;
        logic [ADDR_W-1:0]    addr;
        logic [VAL_W-1:0]     val;
    } s1_t;

    typedef struct packed {
        logic                 byp;
        logic [PIX_W-1:0]     byp_val;
        logic [FRAC_W-1:0]    frac;
        logic [SHIFT_W-1:0]   shift;
        logic                 fin_sel;
        logic [VAL_W-1:0]     fin;
    } s2_t;

    typedef struct packed {
        logic                 byp;
        logic [PIX_W-1:0]     byp_val;
        logic signed [31:0]   prod;
        logic [VAL_W-1:0]     cur;
        logic [SHIFT_W-1:0]   shift;
    } s3_t;

    // Configuration registers
    logic                                           enable_reg;
    logic [PIX_W-1:0]                               boundary_reg [pwl_gamma_pkg::NUM_BND];
    logic [SHIFT_W*pwl_gamma_pkg::NUM_SEG-1:0]      steps_reg;
    logic [BASE_W*pwl_gamma_pkg::NUM_SEG-1:0]       bases_reg;

    // Pipeline state
    logic                 v0_reg, v1_reg, v2_reg, v3_reg, vout_reg;
    s0_t                  s0_reg;
    s1_t                  s1_reg, s1_next;
    s2_t                  s2_reg, s2_next;
    s3_t                  s3_reg, s3_next;
    logic [PIX_W-1:0]     pixel_out_reg, pixel_out_next;

    // Knot storage
    logic [VAL_W-1:0]     knot_mem [pwl_gamma_pkg::TABLE_DEPTH];
    logic [VAL_W-1:0]     final_knot_reg;
    logic [VAL_W-1:0]     cur_rd_reg, nxt_rd_reg;

    // Stage advance chain
    logic                 load_out, load3, load2, load1, load0;
    logic                 req_fire;

    // Stage 2 address path
    logic [PIX_W-1:0]     shifted;
    logic [PIX_W:0]       idx_sum;
    logic [IDX_W-1:0]     idx, idx_inc;
    logic [PIX_W-1:0]     frac_full;
    logic                 wr_tbl, wr_fin;

    // Stage 3 and output arithmetic
    logic [VAL_W-1:0]     next_knot;
    logic signed [16:0]   diff;
    logic signed [32:0]   prod_full;
    logic signed [32:0]   rnd, acc, quo;

    assign load_out = !vout_reg || rsp.ready;
    assign load3    = !v3_reg || load_out;
    assign load2    = !v2_reg || load3;
    assign load1    = !v1_reg || load2;
    assign load0    = !v0_reg || load1;
    assign req.ready = load0;
    assign req_fire = req.valid && load0;

    assign rsp.valid     = vout_reg;
    assign rsp.pixel_out = pixel_out_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            for (int k = 0; k < pwl_gamma_pkg::NUM_BND; k++)
            begin
                boundary_reg[k] <= '0;
            end
            steps_reg <= '0;
            bases_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pwl_gamma_pkg::REG_ENABLE:     enable_reg      <= cfg_data[0];
                pwl_gamma_pkg::REG_BOUNDARY_0: boundary_reg[0] <= cfg_data[PIX_W-1:0];
                pwl_gamma_pkg::REG_BOUNDARY_1: boundary_reg[1] <= cfg_data[PIX_W-1:0];
                pwl_gamma_pkg::REG_BOUNDARY_2: boundary_reg[2] <= cfg_data[PIX_W-1:0];
                pwl_gamma_pkg::REG_BOUNDARY_3: boundary_reg[3] <= cfg_data[PIX_W-1:0];
                pwl_gamma_pkg::REG_BOUNDARY_4: boundary_reg[4] <= cfg_data[PIX_W-1:0];
                pwl_gamma_pkg::REG_STEPS:
                    steps_reg <= cfg_data[SHIFT_W*pwl_gamma_pkg::NUM_SEG-1:0];
                pwl_gamma_pkg::REG_BASES:
                    bases_reg <= cfg_data[BASE_W*pwl_gamma_pkg::NUM_SEG-1:0];
            endcase
        end
    end

    // Stage 1: segment select, lower limit and offset
    always_comb
    begin
        s1_next.wr      = s0_reg.wr;
        s1_next.addr    = s0_reg.addr;
        s1_next.val     = s0_reg.val;
        s1_next.byp     = !enable_reg;
        s1_next.byp_val = s0_reg.pix >> pwl_gamma_pkg::BYPASS_SHIFT;
        s1_next.shift   = steps_reg[SHIFT_W*(pwl_gamma_pkg::NUM_SEG-1) +: SHIFT_W];
        s1_next.base    = bases_reg[BASE_W*(pwl_gamma_pkg::NUM_SEG-1) +: BASE_W];
        s1_next.off     = s0_reg.pix - boundary_reg[pwl_gamma_pkg::NUM_BND-1];
        // last match in a descending walk is the first boundary above
        for (int k = pwl_gamma_pkg::NUM_BND - 1; k >= 0; k--)
        begin
            if (s0_reg.pix < boundary_reg[k])
            begin
                s1_next.shift = steps_reg[SHIFT_W*k +: SHIFT_W];
                s1_next.base  = bases_reg[BASE_W*k +: BASE_W];
                s1_next.off   = (k == 0) ? s0_reg.pix
                                         : s0_reg.pix - boundary_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    // Stage 2: knot index with saturation, fraction, table write decode
    always_comb
    begin
        shifted   = s1_reg.off >> s1_reg.shift;
        idx_sum   = {1'b0, shifted} + (PIX_W+1)'(s1_reg.base);
        idx       = (idx_sum > (PIX_W+1)'(pwl_gamma_pkg::LAST_IDX))
                    ? IDX_W'(pwl_gamma_pkg::LAST_IDX) : idx_sum[IDX_W-1:0];
        idx_inc   = idx + IDX_W'(1);
        frac_full = s1_reg.off & ~({PIX_W{1'b1}} << s1_reg.shift);

        s2_next.byp     = s1_reg.byp;
        s2_next.byp_val = s1_reg.byp_val;
        s2_next.frac    = frac_full[FRAC_W-1:0];
        s2_next.shift   = s1_reg.shift;
        s2_next.fin_sel = (idx == IDX_W'(pwl_gamma_pkg::LAST_IDX));
        s2_next.fin     = final_knot_reg;

        wr_tbl = v1_reg && s1_reg.wr &&
                 (32'(s1_reg.addr) < 32'(pwl_gamma_pkg::TABLE_DEPTH));
        wr_fin = v1_reg && s1_reg.wr &&
                 (32'(s1_reg.addr) == 32'(pwl_gamma_pkg::TABLE_DEPTH));
    end

    // Knot memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (load2)
        begin
            if (wr_tbl)
            begin
                knot_mem[IDX_W'(s1_reg.addr)] <= s1_reg.val;
            end
            cur_rd_reg <= knot_mem[idx];
            nxt_rd_reg <= knot_mem[idx_inc];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load2 && wr_fin)
        begin
            final_knot_reg <= s1_reg.val;
        end
    end

    // Stage 3: signed knot difference times fraction
    always_comb
    begin
        next_knot = s2_reg.fin_sel ? s2_reg.fin : nxt_rd_reg;
        diff      = $signed({1'b0, next_knot}) - $signed({1'b0, cur_rd_reg});
        prod_full = $signed({1'b0, s2_reg.frac}) * diff;

        s3_next.byp     = s2_reg.byp;
        s3_next.byp_val = s2_reg.byp_val;
        s3_next.prod    = prod_full[31:0];
        s3_next.cur     = cur_rd_reg;
        s3_next.shift   = s2_reg.shift;
    end

    // Output stage: round half up, floor shift, add base knot; bypass value passes as is
    always_comb
    begin
        rnd = (s3_reg.shift == '0) ? '0 : (33'sd1 <<< (s3_reg.shift - SHIFT_W'(1)));
        acc = $signed({s3_reg.prod[31], s3_reg.prod}) + rnd;
        quo = acc >>> s3_reg.shift;
        pixel_out_next = s3_reg.byp ? s3_reg.byp_val : (quo[PIX_W-1:0] + s3_reg.cur);
    end

    // Pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            vout_reg <= 1'b0;
        end
        else
        begin
            if (load0)
            begin
                v0_reg <= req.valid;
            end
            if (load1)
            begin
                v1_reg <= v0_reg;
            end
            if (load2)
            begin
                // write items end here
                v2_reg <= v1_reg && !s1_reg.wr;
            end
            if (load3)
            begin
                v3_reg <= v2_reg;
            end
            if (load_out)
            begin
                vout_reg <= v3_reg;
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (load0)
        begin
            s0_reg.wr   <= (req.opcode == pwl_gamma_pkg::OP_WRITE);
            s0_reg.pix  <= req.pixel_in & pwl_gamma_pkg::PIX_MASK;
            s0_reg.addr <= req.table_address;
            s0_reg.val  <= req.table_value;
        end
        if (load1)
        begin
            s1_reg <= s1_next;
        end
        if (load2)
        begin
            s2_reg <= s2_next;
        end
        if (load3)
        begin
            s3_reg <= s3_next;
        end
        if (load_out)
        begin
            pixel_out_reg <= pixel_out_next;
        end
    end

    // Checks
    a_accept_fills_s0: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> v0_reg)
        else $error("accepted item did not enter the input stage");

    a_s3_moves_out: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && load_out) |=> vout_reg)
        else $error("result lost between multiply stage and output");

    a_frac_below_step: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && !s2_reg.byp) |-> ((PIX_W'(s2_reg.frac) >> s2_reg.shift) == '0))
        else $error("fraction not below the segment step");

    a_exact_knot: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !s3_reg.byp && s3_reg.shift == '0) |-> (s3_reg.prod == '0))
        else $error("zero step shift produced a nonzero correction");

endmodule

// ===== tb/sv/gamma_scoreboard_pkg.sv =====
// ============================================================================
// gamma_scoreboard_pkg
// Shadow copy of the gamma block (registers, knot memory, curve math) that
// turns each accepted input item into the pixel the block must return, and
// checks returned pixels in order against those predictions.
// ============================================================================
package gamma_scoreboard_pkg;
    import pwl_gamma_pkg::*;

    // One input item as seen on the request channel
    typedef struct packed {
        logic              opcode;
        logic [PIX_W-1:0]  pixel;
        logic [ADDR_W-1:0] address;
        logic [VAL_W-1:0]  value;
    } gamma_item_t;

    class gamma_scoreboard;
        // Shadow registers
        logic                       enable;
        logic [PIX_W-1:0]           boundary [NUM_BND];
        logic [NUM_SEG*SHIFT_W-1:0] step_shifts;
        logic [NUM_SEG*BASE_W-1:0]  segment_bases;

        // Shadow knot memory
        logic [VAL_W-1:0]           knots [TABLE_DEPTH];
        logic [VAL_W-1:0]           final_knot;

        // Pixels still owed by the block, oldest first
        logic [PIX_W-1:0]           expected_pixels [$];
        int                         error_count;

        function new();
            enable        = 1'b0;
            step_shifts   = '0;
            segment_bases = '0;
            final_knot    = '0;
            error_count   = 0;
            foreach (boundary[k])
                boundary[k] = '0;
            foreach (knots[k])
                knots[k] = '0;
        endfunction

        function void write_reg(cfg_reg_t index, logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_ENABLE:
                    enable = data[0];
                REG_BOUNDARY_0, REG_BOUNDARY_1, REG_BOUNDARY_2, REG_BOUNDARY_3,
                REG_BOUNDARY_4:
                    boundary[int'(index) - int'(REG_BOUNDARY_0)] = data[PIX_W-1:0];
                REG_STEPS:
                    step_shifts = data[NUM_SEG*SHIFT_W-1:0];
                REG_BASES:
                    segment_bases = data[NUM_SEG*BASE_W-1:0];
                default: ;
            endcase
        endfunction

        // Index past the table body lands on the final knot
        function logic [VAL_W-1:0] knot_at(int idx);
            if (idx < TABLE_DEPTH)
                return knots[idx];
            return final_knot;
        endfunction

        function logic [PIX_W-1:0] gamma_curve(logic [PIX_W-1:0] x);
            int     seg;
            int     lower;
            int     shamt;
            int     offset;
            int     idx;
            int     frac;
            longint cur;
            longint nxt;
            longint acc;

            // Lowest boundary above the pixel picks the segment
            seg = NUM_SEG - 1;
            for (int k = NUM_BND - 1; k >= 0; k--)
                if (x < boundary[k])
                    seg = k;

            lower  = (seg == 0) ? 0 : int'(boundary[seg - 1]);
            shamt  = int'(step_shifts[seg*SHIFT_W +: SHIFT_W]);
            offset = int'(x) - lower;
            idx    = (offset >>> shamt) + int'(segment_bases[seg*BASE_W +: BASE_W]);
            if (idx > LAST_IDX)
                idx = LAST_IDX;

            cur = longint'(knot_at(idx));
            if (shamt == 0)
                return cur[PIX_W-1:0];

            // Signed slope, round half up; arithmetic shift floors negatives
            frac = offset & ((1 << shamt) - 1);
            nxt  = longint'(knot_at(idx + 1));
            acc  = longint'(frac) * (nxt - cur) + (longint'(1) << (shamt - 1));
            acc  = (acc >>> shamt) + cur;
            return acc[PIX_W-1:0];
        endfunction

        function void note_item(gamma_item_t item);
            logic [PIX_W-1:0] px;

            px = item.pixel & PIX_MASK;
            if (item.opcode == OP_WRITE) begin
                if (int'(item.address) < TABLE_DEPTH)
                    knots[item.address[IDX_W-1:0]] = item.value;
                else if (int'(item.address) == TABLE_DEPTH)
                    final_knot = item.value;
            end
            else if (enable)
                expected_pixels.push_back(gamma_curve(px));
            else
                expected_pixels.push_back(px >> BYPASS_SHIFT);
        endfunction

        function void check_pixel(logic [PIX_W-1:0] actual);
            logic [PIX_W-1:0] expected;

            if (expected_pixels.size() == 0) begin
                $error("pixel_out: none expected, actual %h", actual);
                error_count++;
                return;
            end
            expected = expected_pixels.pop_front();
            if (actual !== expected) begin
                $error("pixel_out mismatch: expected %h, actual %h", expected, actual);
                error_count++;
            end
        endfunction

        function int outstanding();
            return expected_pixels.size();
        endfunction
    endclass

endpackage

// ===== tb/sv/tb_top.sv =====
// ============================================================================
// tb_top
// Drives the piecewise linear gamma block with knot loads, directed pixels
// around segment edges and extremes, then randomized curves and streams,
// with random stalls on both channels; results are checked in order.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pwl_gamma_pkg::*;
    import gamma_scoreboard_pkg::*;

    localparam int SETTLE_CYCLES = 10;
    localparam int STALL_LIMIT   = 4000;
    localparam int IDLE_PCT      = 37;
    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_ITEMS   = 70;
    localparam int HOLD_PHASE    = 3;
    localparam int STEADY_PHASE  = 1;

    // Pixels at range ends and around most edges of the six-segment curve
    localparam logic [PIX_W-1:0] CURVE_PIXELS [11] = '{
        16'h0000, 16'h003F, 16'h0040, 16'h03FF, 16'h0400, 16'h0FFF,
        16'h1000, 16'h8000, 16'hBFFF, 16'hC000, 16'hFFFF
    };

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;
    logic [NUM_BND*PIX_W-1:0]  cur_bounds;
    bit                        steady;
    int                        quiet_cycles;
    gamma_scoreboard           sb;

    pwl_gamma_req_if req_ch ();
    pwl_gamma_rsp_if rsp_ch ();

    piecewise_linear_gamma_lut u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Result side back-pressure
    always @(negedge clk)
    begin
        rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Check results, then record accepted items
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_pixel(rsp_ch.pixel_out);
            if (req_ch.valid && req_ch.ready)
                sb.note_item(gamma_item_t'({req_ch.opcode, req_ch.pixel_in,
                                            req_ch.table_address, req_ch.table_value}));
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Present one item, hold it until accepted; returns on a falling edge
    task automatic send(gamma_item_t item);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid         = 1'b1;
        req_ch.opcode        = item.opcode;
        req_ch.pixel_in      = item.pixel;
        req_ch.table_address = item.address;
        req_ch.table_value   = item.value;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    // Unused fields carry junk so the block must ignore them
    task automatic send_pixel(logic [PIX_W-1:0] px);
        gamma_item_t item;

        item.opcode  = OP_PIXEL;
        item.pixel   = px;
        item.address = ADDR_W'($urandom());
        item.value   = VAL_W'($urandom());
        send(item);
    endtask

    task automatic send_write(logic [ADDR_W-1:0] addr, logic [VAL_W-1:0] val);
        gamma_item_t item;

        item.opcode  = OP_WRITE;
        item.pixel   = PIX_W'($urandom());
        item.address = addr;
        item.value   = val;
        send(item);
    endtask

    // Stop sending until every owed pixel is back, then let the pipe settle
    task automatic drain(int settle);
        req_ch.valid = 1'b0;
        while (sb.outstanding() != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    // Write all registers back to back; pipeline must be empty
    task automatic configure(logic en, logic [NUM_BND*PIX_W-1:0] bounds,
                             logic [NUM_SEG*SHIFT_W-1:0] steps,
                             logic [NUM_SEG*BASE_W-1:0] bases);
        logic [CFG_DATA_W-1:0] data;
        cfg_reg_t              r;

        cur_bounds = bounds;
        cfg_we     = 1'b1;
        for (int i = int'(REG_ENABLE); i <= int'(REG_BASES); i++) begin
            r = cfg_reg_t'(i);
            case (r)
                REG_ENABLE: data = CFG_DATA_W'(en);
                REG_STEPS:  data = CFG_DATA_W'(steps);
                REG_BASES:  data = CFG_DATA_W'(bases);
                default:
                    data = CFG_DATA_W'(bounds[(i - int'(REG_BOUNDARY_0))*PIX_W +: PIX_W]);
            endcase
            cfg_index = r;
            cfg_data  = data;
            sb.write_reg(r, data);
            @(negedge clk);
        end
        cfg_we = 1'b0;
    endtask

    // Fill every knot plus the final entry; rising curve or random values
    task automatic load_table(bit rising);
        logic [VAL_W-1:0] level;

        level = VAL_W'($urandom_range(255));
        for (int a = 0; a <= TABLE_DEPTH; a++) begin
            send_write(ADDR_W'(a), rising ? level : VAL_W'($urandom()));
            level = level + VAL_W'($urandom_range(900));
        end
    endtask

    task automatic random_settings();
        logic [PIX_W-1:0]         picks [$];
        logic [NUM_BND*PIX_W-1:0] packed_bounds;

        repeat (NUM_BND) picks.push_back(PIX_W'($urandom()));
        if ($urandom_range(9) < 7)
            picks.sort();
        foreach (picks[k])
            packed_bounds[k*PIX_W +: PIX_W] = picks[k];
        configure($urandom_range(9) != 0, packed_bounds,
                  (NUM_SEG*SHIFT_W)'($urandom()),
                  (NUM_SEG*BASE_W)'({$urandom(), $urandom()}));
    endtask

    // Favor segment edges and range ends over plain uniform pixels
    function automatic logic [PIX_W-1:0] pick_pixel();
        int k;

        case ($urandom_range(9))
            0, 1: begin
                k = $urandom_range(NUM_BND - 1);
                return cur_bounds[k*PIX_W +: PIX_W] + PIX_W'($urandom_range(2)) - PIX_W'(1);
            end
            2:       return $urandom_range(1) ? '1 : '0;
            3:       return PIX_W'($urandom_range(255));
            default: return PIX_W'($urandom());
        endcase
    endfunction

    // Mostly pixels, some knot rewrites, a few writes past the final entry
    task automatic random_item();
        int r;

        r = $urandom_range(99);
        if (r < 80)
            send_pixel(pick_pixel());
        else if (r < 95)
            send_write(ADDR_W'($urandom_range(TABLE_DEPTH)), VAL_W'($urandom()));
        else
            send_write(ADDR_W'($urandom_range(127, TABLE_DEPTH + 1)), VAL_W'($urandom()));
    endtask

    initial
    begin
        sb                   = new();
        rst_n                = 1'b0;
        steady               = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = REG_ENABLE;
        cfg_data             = '0;
        cur_bounds           = '0;
        req_ch.valid         = 1'b0;
        req_ch.opcode        = OP_PIXEL;
        req_ch.pixel_in      = '0;
        req_ch.table_address = '0;
        req_ch.table_value   = '0;
        rsp_ch.ready         = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Bypass mode; load knots, writes past the final entry must be dropped
        configure(1'b0, '0, '0, '0);
        load_table(1'b1);
        send_write(ADDR_W'(TABLE_DEPTH + 1), 16'hDEAD);
        send_write('1, 16'hBEEF);
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        send_pixel(16'h0010);
        send_pixel(16'h000F);
        drain(SETTLE_CYCLES);

        // Six-segment curve, every segment interpolated
        configure(1'b1, {16'hC000, 16'h4000, 16'h1000, 16'h0400, 16'h0040}, 24'hFCA862,
                  {6'd63, 6'd55, 6'd43, 6'd31, 6'd16, 6'd0});
        foreach (CURVE_PIXELS[k])
            send_pixel(CURVE_PIXELS[k]);
        drain(SETTLE_CYCLES);

        // Register extremes; falling last knot pair gives a negative slope
        configure(1'b1, '1, '1, '1);
        send_write(ADDR_W'(LAST_IDX), 16'hFFFF);
        send_write(ADDR_W'(TABLE_DEPTH), 16'h0000);
        send_pixel(16'h0000);
        send_pixel(16'h7FFF);
        send_pixel(16'h4001);
        send_pixel(16'hFFFF);
        drain(SETTLE_CYCLES);

        // Single segment with zero shift: exact knots, index saturation
        configure(1'b1, '0, '0, '0);
        send_pixel(16'h0000);
        send_pixel(16'h003E);
        send_pixel(16'h003F);
        send_pixel(16'h0040);
        send_pixel(16'hFFFF);
        drain(SETTLE_CYCLES);

        // Random curves and streams
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            steady = (p == STEADY_PHASE);
            random_settings();
            if (p % 2 == 0)
                load_table($urandom_range(1) != 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == HOLD_PHASE && n == PHASE_ITEMS / 2)
                    drain(0);
                random_item();
            end
            drain(SETTLE_CYCLES);
        end
        steady = 1'b0;

        if (sb.error_count == 0 && sb.outstanding() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/pwl_gamma_pkg.sv
rtl/core/pwl_gamma_if.sv
rtl/core/piecewise_linear_gamma_lut.sv
tb/sv/gamma_scoreboard_pkg.sv
tb/sv/tb_top.sv
